>>> rtl/tess_pkg.sv
// Shared constants, operation and status codes, and control types for the two-ended stack.
`default_nettype none
package tess_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int WORD_WIDTH  = 32;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int OP_W        = 3;
    localparam int ST_W        = 2;
    localparam int USER_W      = OP_W + 1;

    localparam int IN_TDATA_W  = ((WORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_BITS    = ST_W + WORD_WIDTH + ADDR_W + 1 + 3 * CNT_W + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;
    localparam logic [OP_W-1:0] OP_STATUS = 3'd5;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic take;
        logic read_done;
        logic srch_run;
        logic srch_done;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic need_read;
        logic is_search;
        logic srch_end;
    } t_stat;

endpackage
`default_nettype wire

>>> rtl/tess_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module tess_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule
`default_nettype wire

>>> rtl/tess_ctrl.sv
// Controller state machine: accepts items and sequences store reads and searches.
`default_nettype none
module tess_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    input  wire tess_pkg::t_stat i_stat,
    output logic                o_s_tready,
    output tess_pkg::t_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = i_stat.out_free;
                o_cmd.take = i_s_tvalid && i_stat.out_free;
                if (o_cmd.take) begin
                    if (i_stat.need_read) begin
                        n_state = S_READ;
                    end else if (i_stat.is_search) begin
                        n_state = S_SRCH;
                    end
                end
            end
            S_READ: begin
                o_cmd.read_done = 1'b1;
                n_state         = S_IDLE;
            end
            S_SRCH: begin
                o_cmd.srch_run = 1'b1;
                if (i_stat.srch_end) begin
                    o_cmd.srch_done = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

>>> rtl/tess_dp.sv
// Datapath: stack counts, capacity, word store, search walk and result register.
`default_nettype none
module tess_dp (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire tess_pkg::t_cmd                   i_cmd,
    output tess_pkg::t_stat                       o_stat,
    input  wire logic                             i_cfg_valid,
    input  wire logic [tess_pkg::CNT_W-1:0]       i_cfg_data,
    input  wire logic [tess_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic [tess_pkg::USER_W-1:0]      i_s_tuser,
    input  wire logic                             i_m_tready,
    output logic                                  o_m_tvalid,
    output logic      [tess_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int AW = tess_pkg::ADDR_W;
    localparam int CW = tess_pkg::CNT_W;
    localparam int WW = tess_pkg::WORD_WIDTH;

    logic [tess_pkg::OP_W-1:0] w_op;
    logic                      w_sel_back;
    logic [WW-1:0]             w_word;

    logic [CW-1:0] r_front, r_back, r_cap;
    logic [CW-1:0] n_front, n_back, n_cap;
    logic [CW-1:0] w_total, w_cap_m_back, w_push_back, w_front_m1;
    logic          w_full, w_sel_empty, w_is_rd;

    logic          w_we, w_re;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [WW-1:0] w_rdata;

    logic [WW-1:0] r_word;
    logic [CW-1:0] r_srch_left;
    logic [AW-1:0] r_saddr, r_pend_addr;
    logic          r_sback, r_pend_back, r_pend_valid;
    logic          w_hit, w_issue;

    logic                      r_out_valid;
    logic [tess_pkg::ST_W-1:0] r_status, n_status;
    logic [WW-1:0]             r_data, n_data;
    logic [AW-1:0]             r_idx, n_idx;
    logic                      r_inback, n_inback;
    logic [CW-1:0]             r_ofront, r_oback, r_ototal, n_ototal;
    logic                      r_ofull;
    logic                      w_load;

    assign w_op       = i_s_tuser[tess_pkg::OP_W-1:0];
    assign w_sel_back = i_s_tuser[tess_pkg::OP_W];
    assign w_word     = i_s_tdata[WW-1:0];

    assign w_total      = r_front + r_back;
    assign w_full       = w_total >= r_cap;
    assign w_cap_m_back = r_cap - r_back;
    assign w_push_back  = w_cap_m_back - CW'(1);
    assign w_front_m1   = r_front - CW'(1);
    assign w_sel_empty  = w_sel_back ? (r_back == '0) : (r_front == '0);
    assign w_is_rd      = (w_op == tess_pkg::OP_POP) || (w_op == tess_pkg::OP_PEEK);

    assign w_hit   = r_pend_valid && (w_rdata == r_word);
    assign w_issue = (r_srch_left != '0) && !w_hit;

    assign o_stat.out_free  = !r_out_valid || i_m_tready;
    assign o_stat.need_read = w_is_rd && !w_sel_empty;
    assign o_stat.is_search = (w_op == tess_pkg::OP_SEARCH);
    assign o_stat.srch_end  = w_hit || (!r_pend_valid && (r_srch_left == '0));

    always_comb begin
        n_front = r_front;
        n_back  = r_back;
        n_cap   = r_cap;
        if (i_cfg_valid) begin
            n_front = '0;
            n_back  = '0;
            if (i_cfg_data == '0) begin
                n_cap = CW'(1);
            end else if (i_cfg_data > CW'(tess_pkg::STORE_DEPTH)) begin
                n_cap = CW'(tess_pkg::STORE_DEPTH);
            end else begin
                n_cap = i_cfg_data;
            end
        end else if (i_cmd.take) begin
            case (w_op)
                tess_pkg::OP_PUSH: begin
                    if (!w_full) begin
                        if (w_sel_back) begin
                            n_back = r_back + CW'(1);
                        end else begin
                            n_front = r_front + CW'(1);
                        end
                    end
                end
                tess_pkg::OP_POP: begin
                    if (!w_sel_empty) begin
                        if (w_sel_back) begin
                            n_back = r_back - CW'(1);
                        end else begin
                            n_front = w_front_m1;
                        end
                    end
                end
                tess_pkg::OP_CLEAR: begin
                    n_front = '0;
                    n_back  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_we    = i_cmd.take && (w_op == tess_pkg::OP_PUSH) && !w_full;
    assign w_waddr = w_sel_back ? w_push_back[AW-1:0] : r_front[AW-1:0];
    assign w_re    = (i_cmd.take && o_stat.need_read) || (i_cmd.srch_run && w_issue);
    assign w_raddr = i_cmd.take ? (w_sel_back ? w_cap_m_back[AW-1:0] : w_front_m1[AW-1:0])
                                : r_saddr;

    tess_ram #(
        .WIDTH (WW),
        .DEPTH (tess_pkg::STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_word),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_load   = 1'b0;
        n_status = tess_pkg::ST_OK;
        n_data   = '0;
        n_idx    = '0;
        n_inback = 1'b0;
        n_ototal = n_front + n_back;
        if (i_cmd.take && !o_stat.need_read && !o_stat.is_search) begin
            w_load = 1'b1;
            if ((w_op == tess_pkg::OP_PUSH) && w_full) begin
                n_status = tess_pkg::ST_FULL;
            end else if (w_is_rd) begin
                n_status = tess_pkg::ST_EMPTY;
            end
        end else if (i_cmd.read_done) begin
            w_load = 1'b1;
            n_data = w_rdata;
        end else if (i_cmd.srch_done) begin
            w_load = 1'b1;
            if (w_hit) begin
                n_idx    = r_pend_addr;
                n_inback = r_pend_back;
            end else begin
                n_status = tess_pkg::ST_NOTFOUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front      <= '0;
            r_back       <= '0;
            r_cap        <= CW'(tess_pkg::STORE_DEPTH);
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_srch_left  <= '0;
        end else begin
            r_front <= n_front;
            r_back  <= n_back;
            r_cap   <= n_cap;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.take && o_stat.is_search) begin
                r_pend_valid <= 1'b0;
                r_srch_left  <= w_total;
            end else if (i_cmd.srch_run) begin
                r_pend_valid <= w_issue;
                if (w_issue) begin
                    r_srch_left <= r_srch_left - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && o_stat.is_search) begin
            r_word <= w_word;
            if (r_front == '0) begin
                r_saddr <= w_cap_m_back[AW-1:0];
                r_sback <= 1'b1;
            end else begin
                r_saddr <= w_front_m1[AW-1:0];
                r_sback <= 1'b0;
            end
        end else if (i_cmd.srch_run) begin
            r_pend_addr <= r_saddr;
            r_pend_back <= r_sback;
            if (w_issue) begin
                if (!r_sback && (r_saddr == '0)) begin
                    r_saddr <= w_cap_m_back[AW-1:0];
                    r_sback <= 1'b1;
                end else if (r_sback) begin
                    r_saddr <= r_saddr + AW'(1);
                end else begin
                    r_saddr <= r_saddr - AW'(1);
                end
            end
        end
        if (w_load) begin
            r_status <= n_status;
            r_data   <= n_data;
            r_idx    <= n_idx;
            r_inback <= n_inback;
            r_ofront <= n_front;
            r_oback  <= n_back;
            r_ototal <= n_ototal;
            r_ofull  <= n_ototal >= r_cap;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(tess_pkg::OUT_TDATA_W - tess_pkg::OUT_BITS){1'b0}},
                         r_ofull, r_ototal, r_oback, r_ofront,
                         r_inback, r_idx, r_data, r_status};

endmodule
`default_nettype wire

>>> rtl/two_ended_shared_stack.sv
// Top level of the two-ended shared stack: controller, datapath and port wiring.
//
// Channel   Direction  Transfer on               Carries
// s_axis    in         tvalid & tready           one operation (tuser) with its word (tdata)
// m_axis    out        tvalid & tready           one result with counts and full flag
// cfg       in         i_cfg_valid & o_cfg_ready capacity in use (empties both stacks)
//
// Push, clear, status and failed pop or peek: result loaded at the transfer.
// Pop and peek: result loaded from the registered read of the word store in the read state.
// Search: walks front stack top down, then back stack from its top; a match ends it early.
// Reset: synchronous; capacity 256, both counts zero, store contents left as they are.
// When idle, an item is taken once the result register is empty or its result is transferred.
`default_nettype none
module two_ended_shared_stack (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // value
    input  wire logic [tess_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // operation, which_stack
    input  wire logic [tess_pkg::USER_W-1:0]      s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // status, data_out, found_index, found_in_back, front_count, back_count,
    // total_count, is_full, zero pad
    output logic      [tess_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [tess_pkg::CNT_W-1:0]       i_cfg_data
);

    tess_pkg::t_cmd  w_cmd;
    tess_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    tess_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_stat     (w_stat),
        .o_s_tready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    tess_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule
`default_nettype wire

>>> rtl/tess_chk.sv
// Port-level checker for the two-ended shared stack, bound to the top level.
`default_nettype none
module tess_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [tess_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int WW   = tess_pkg::WORD_WIDTH;
    localparam int AW   = tess_pkg::ADDR_W;
    localparam int CW   = tess_pkg::CNT_W;
    localparam int SW   = tess_pkg::ST_W;
    localparam int D_LO = SW;
    localparam int B_LO = D_LO + WW + AW;
    localparam int F_LO = B_LO + 1;
    localparam int K_LO = F_LO + CW;
    localparam int T_LO = K_LO + CW;
    localparam int U_LO = T_LO + CW;

    logic [SW-1:0] w_status;
    logic [WW-1:0] w_data;
    logic          w_inback;
    logic [CW-1:0] w_front, w_back, w_total;
    logic          w_full;

    assign w_status = m_axis_tdata[SW-1:0];
    assign w_data   = m_axis_tdata[D_LO +: WW];
    assign w_inback = m_axis_tdata[B_LO];
    assign w_front  = m_axis_tdata[F_LO +: CW];
    assign w_back   = m_axis_tdata[K_LO +: CW];
    assign w_total  = m_axis_tdata[T_LO +: CW];
    assign w_full   = m_axis_tdata[U_LO];

    a_total_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_total == (w_front + w_back)))
        else $error("total_count differs from front_count + back_count");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_status == tess_pkg::ST_FULL)) |-> w_full)
        else $error("push reported full while is_full is low");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_status != tess_pkg::ST_OK)) |-> ((w_data == '0) && !w_inback))
        else $error("failed operation carries data or a back-stack match");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

endmodule

bind two_ended_shared_stack tess_chk u_tess_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

>>> tb/tb_two_ended_shared_stack.sv
// Self-checking testbench for the two-ended shared stack: directed script, then random phases.
module tb_two_ended_shared_stack;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW    = tess_pkg::ADDR_W;
    localparam int CW    = tess_pkg::CNT_W;
    localparam int WW    = tess_pkg::WORD_WIDTH;
    localparam int OW    = tess_pkg::OP_W;
    localparam int SW    = tess_pkg::ST_W;
    localparam int DEPTH = tess_pkg::STORE_DEPTH;

    localparam logic [OW-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OW-1:0] OP_UNUSED_7 = 3'd7;

    // status sits in the lowest bits, as on m_axis_tdata
    typedef struct packed {
        logic          is_full;
        logic [CW-1:0] total_cnt;
        logic [CW-1:0] back_cnt;
        logic [CW-1:0] front_cnt;
        logic          in_back;
        logic [AW-1:0] idx;
        logic [WW-1:0] data;
        logic [SW-1:0] st;
    } t_stack_res;

    typedef struct {
        bit            is_cap;
        logic [CW-1:0] cap;
        logic [OW-1:0] op;
        logic          which;
        logic [WW-1:0] val;
        bit            typed;
        t_stack_res    res;
    } t_script_row;

    typedef enum {FILL_RUN, DRAIN_RUN, MIXED_RUN} t_run_mode;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [tess_pkg::IN_TDATA_W-1:0]    s_axis_tdata = '0;
    logic [tess_pkg::USER_W-1:0]        s_axis_tuser = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [tess_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [CW-1:0]                      i_cfg_data = '0;

    // expectation typed into the script for the item currently offered
    bit                     row_typed = 1'b0;
    t_stack_res             row_res = '0;

    // predictor state
    logic [WW-1:0]          word_store [DEPTH];
    int                     front_n = 0;
    int                     back_n = 0;
    int                     cap_n = DEPTH;

    t_stack_res             awaited_results [$];
    t_script_row            script [$];
    logic [WW-1:0]          word_pool [8] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000,
                                              32'h7FFF_FFFF, 32'h5, 32'h2A, 32'h5555_5555};

    int  errors = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  n_full = 0;
    int  n_empty = 0;
    int  n_hit = 0;
    int  n_miss = 0;
    int  n_cap = 0;
    bit  calm_tx = 1'b0;
    bit  calm_rx = 1'b0;
    int  stall_left = 0;

    t_stack_res got_res;
    t_stack_res want_res;

    two_ended_shared_stack dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_stack_res mk_res(logic [SW-1:0] st, logic [WW-1:0] data,
                                          int idx, logic inb, int fc, int bc, logic full);
        t_stack_res r;
        r.st        = st;
        r.data      = data;
        r.idx       = AW'(idx);
        r.in_back   = inb;
        r.front_cnt = CW'(fc);
        r.back_cnt  = CW'(bc);
        r.total_cnt = CW'(fc + bc);
        r.is_full   = full;
        return r;
    endfunction

    function automatic t_script_row op_row(logic [OW-1:0] op, logic which,
                                           logic [WW-1:0] val);
        t_script_row r;
        r = '{default: '0};
        r.op    = op;
        r.which = which;
        r.val   = val;
        return r;
    endfunction

    function automatic t_script_row chk_row(logic [OW-1:0] op, logic which,
                                            logic [WW-1:0] val, t_stack_res res);
        t_script_row r;
        r = op_row(op, which, val);
        r.typed = 1'b1;
        r.res   = res;
        return r;
    endfunction

    function automatic t_script_row cap_row(logic [CW-1:0] v);
        t_script_row r;
        r = '{default: '0};
        r.is_cap = 1'b1;
        r.cap    = v;
        return r;
    endfunction

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [OW-1:0] pick_op(t_run_mode m);
        int r, k, t_push, t_pop, t_peek, t_srch, t_stat;
        r = $urandom_range(0, 99);
        case (m)
            FILL_RUN: begin
                t_push = 82; t_pop = 87; t_peek = 90; t_srch = 96; t_stat = 99;
            end
            DRAIN_RUN: begin
                t_push = 20; t_pop = 70; t_peek = 82; t_srch = 94; t_stat = 98;
            end
            default: begin
                t_push = 35; t_pop = 60; t_peek = 72; t_srch = 92; t_stat = 98;
            end
        endcase
        k = $urandom_range(0, 2);
        if (r < t_push)
            return tess_pkg::OP_PUSH;
        if (r < t_pop)
            return tess_pkg::OP_POP;
        if (r < t_peek)
            return tess_pkg::OP_PEEK;
        if (r < t_srch)
            return tess_pkg::OP_SEARCH;
        if (r < t_stat)
            return (k == 0) ? tess_pkg::OP_STATUS : ((k == 1) ? OP_UNUSED_6 : OP_UNUSED_7);
        return tess_pkg::OP_CLEAR;
    endfunction

    // pick a word: for a search, mostly one held in the stacks; else from the pool or random
    function automatic logic [WW-1:0] pick_word(logic [OW-1:0] op);
        if (op == tess_pkg::OP_SEARCH && front_n + back_n > 0
            && $urandom_range(0, 99) < 70) begin
            if (front_n > 0 && (back_n == 0 || $urandom_range(0, 1) == 0))
                return word_store[$urandom_range(0, front_n - 1)];
            return word_store[cap_n - 1 - $urandom_range(0, back_n - 1)];
        end
        if ($urandom_range(0, 99) < 40)
            return word_pool[$urandom_range(0, 7)];
        return WW'($urandom);
    endfunction

    function automatic t_stack_res apply_stack_op(logic [OW-1:0] op, logic which,
                                                  logic [WW-1:0] w);
        t_stack_res r;
        int         i;
        bit         hit;
        r   = '0;
        hit = 1'b0;
        case (op)
            tess_pkg::OP_PUSH: begin
                if (front_n + back_n >= cap_n) begin
                    r.st = tess_pkg::ST_FULL;
                end else if (!which) begin
                    word_store[front_n] = w;
                    front_n++;
                end else begin
                    word_store[cap_n - 1 - back_n] = w;
                    back_n++;
                end
            end
            tess_pkg::OP_POP, tess_pkg::OP_PEEK: begin
                if (!which) begin
                    if (front_n == 0) begin
                        r.st = tess_pkg::ST_EMPTY;
                    end else begin
                        r.data = word_store[front_n - 1];
                        if (op == tess_pkg::OP_POP)
                            front_n--;
                    end
                end else begin
                    if (back_n == 0) begin
                        r.st = tess_pkg::ST_EMPTY;
                    end else begin
                        r.data = word_store[cap_n - back_n];
                        if (op == tess_pkg::OP_POP)
                            back_n--;
                    end
                end
            end
            tess_pkg::OP_SEARCH: begin
                for (i = front_n - 1; i >= 0 && !hit; i--) begin
                    if (word_store[i] == w) begin
                        hit   = 1'b1;
                        r.idx = AW'(i);
                    end
                end
                for (i = cap_n - back_n; i < cap_n && !hit; i++) begin
                    if (word_store[i] == w) begin
                        hit       = 1'b1;
                        r.idx     = AW'(i);
                        r.in_back = 1'b1;
                    end
                end
                if (!hit)
                    r.st = tess_pkg::ST_NOTFOUND;
            end
            tess_pkg::OP_CLEAR: begin
                front_n = 0;
                back_n  = 0;
            end
            default: begin
            end
        endcase
        r.front_cnt = CW'(front_n);
        r.back_cnt  = CW'(back_n);
        r.total_cnt = CW'(front_n + back_n);
        r.is_full   = (front_n + back_n >= cap_n);
        return r;
    endfunction

    function automatic int field_diff(string name, logic [WW-1:0] want,
                                      logic [WW-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // result check, capacity writes and prediction, in that order at each edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_res = t_stack_res'(m_axis_tdata[tess_pkg::OUT_BITS-1:0]);
                n_results++;
                if (got_res.st == tess_pkg::ST_FULL)
                    n_full++;
                if (got_res.st == tess_pkg::ST_EMPTY)
                    n_empty++;
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with no expectation, expected none, got %h",
                             $time, m_axis_tdata);
                    errors++;
                end else begin
                    want_res = awaited_results.pop_front();
                    errors += field_diff("status", want_res.st, got_res.st);
                    errors += field_diff("data_out", want_res.data, got_res.data);
                    errors += field_diff("found_index", want_res.idx, got_res.idx);
                    errors += field_diff("found_in_back", want_res.in_back, got_res.in_back);
                    errors += field_diff("front_count", want_res.front_cnt, got_res.front_cnt);
                    errors += field_diff("back_count", want_res.back_cnt, got_res.back_cnt);
                    errors += field_diff("total_count", want_res.total_cnt, got_res.total_cnt);
                    errors += field_diff("is_full", want_res.is_full, got_res.is_full);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cap_n   = (i_cfg_data == 0) ? 1 :
                          ((int'(i_cfg_data) > DEPTH) ? DEPTH : int'(i_cfg_data));
                front_n = 0;
                back_n  = 0;
                n_cap++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want_res = apply_stack_op(s_axis_tuser[OW-1:0], s_axis_tuser[OW],
                                          s_axis_tdata[WW-1:0]);
                if (s_axis_tuser[OW-1:0] == tess_pkg::OP_SEARCH) begin
                    if (want_res.st == tess_pkg::ST_OK)
                        n_hit++;
                    else
                        n_miss++;
                end
                awaited_results.push_back(row_typed ? row_res : want_res);
                n_items++;
            end
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        int g;
        if ($urandom_range(0, 149) == 0)
            calm_rx <= ~calm_rx;
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            g = pick_gap(calm_rx);
            if (g > 0) begin
                stall_left    <= g - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send(logic [OW-1:0] op, logic which, logic [WW-1:0] val,
                        bit typed, t_stack_res res, bit lower_after);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= {which, op};
        row_typed     <= typed;
        row_res       <= res;
        do @(posedge i_clk); while (!s_axis_tready);
        gap = pick_gap(calm_tx);
        if (lower_after && gap == 0)
            gap = 1;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_capacity(logic [CW-1:0] v);
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CW-1:0]  cap_plan [$];
        t_run_mode      mode;
        logic [OW-1:0]  op;
        logic [WW-1:0]  val;
        int             k, p, n, eff, left_in_run;

        foreach (word_store[i])
            word_store[i] = '0;

        script.push_back(chk_row(tess_pkg::OP_STATUS, 0, 0,
                                 mk_res(tess_pkg::ST_OK, 0, 0, 0, 0, 0, 0)));
        script.push_back(chk_row(tess_pkg::OP_POP, 0, 0,
                                 mk_res(tess_pkg::ST_EMPTY, 0, 0, 0, 0, 0, 0)));
        script.push_back(chk_row(tess_pkg::OP_PEEK, 1, 0,
                                 mk_res(tess_pkg::ST_EMPTY, 0, 0, 0, 0, 0, 0)));
        script.push_back(chk_row(tess_pkg::OP_SEARCH, 0, 0,
                                 mk_res(tess_pkg::ST_NOTFOUND, 0, 0, 0, 0, 0, 0)));
        script.push_back(chk_row(tess_pkg::OP_PUSH, 0, 32'h7FFF_FFFF,
                                 mk_res(tess_pkg::ST_OK, 0, 0, 0, 1, 0, 0)));
        script.push_back(chk_row(tess_pkg::OP_PUSH, 1, 32'h8000_0000,
                                 mk_res(tess_pkg::ST_OK, 0, 0, 0, 1, 1, 0)));
        script.push_back(chk_row(tess_pkg::OP_PEEK, 0, 0,
                                 mk_res(tess_pkg::ST_OK, 32'h7FFF_FFFF, 0, 0, 1, 1, 0)));
        script.push_back(chk_row(tess_pkg::OP_PEEK, 1, 0,
                                 mk_res(tess_pkg::ST_OK, 32'h8000_0000, 0, 0, 1, 1, 0)));
        script.push_back(chk_row(tess_pkg::OP_SEARCH, 1, 32'h8000_0000,
                                 mk_res(tess_pkg::ST_OK, 0, 255, 1, 1, 1, 0)));
        script.push_back(chk_row(tess_pkg::OP_SEARCH, 0, 32'h7FFF_FFFF,
                                 mk_res(tess_pkg::ST_OK, 0, 0, 0, 1, 1, 0)));
        script.push_back(op_row(tess_pkg::OP_PUSH, 0, 32'hFFFF_FFFF));
        script.push_back(op_row(tess_pkg::OP_PUSH, 1, 32'h0));
        script.push_back(op_row(tess_pkg::OP_SEARCH, 0, 32'h0));
        script.push_back(op_row(tess_pkg::OP_POP, 0, 0));
        script.push_back(op_row(tess_pkg::OP_POP, 1, 0));
        script.push_back(chk_row(OP_UNUSED_6, 1, 32'hFFFF_FFFF,
                                 mk_res(tess_pkg::ST_OK, 0, 0, 0, 1, 1, 0)));
        script.push_back(chk_row(tess_pkg::OP_CLEAR, 0, 0,
                                 mk_res(tess_pkg::ST_OK, 0, 0, 0, 0, 0, 0)));
        script.push_back(cap_row(0));
        script.push_back(chk_row(tess_pkg::OP_PUSH, 1, 32'h5,
                                 mk_res(tess_pkg::ST_OK, 0, 0, 0, 0, 1, 1)));
        script.push_back(chk_row(tess_pkg::OP_PUSH, 0, 32'h6,
                                 mk_res(tess_pkg::ST_FULL, 0, 0, 0, 0, 1, 1)));
        script.push_back(chk_row(tess_pkg::OP_POP, 1, 0,
                                 mk_res(tess_pkg::ST_OK, 32'h5, 0, 0, 0, 0, 0)));
        script.push_back(cap_row(2));
        script.push_back(op_row(tess_pkg::OP_PUSH, 0, 32'hAAAA_AAAA));
        script.push_back(op_row(tess_pkg::OP_PUSH, 1, 32'h5555_5555));
        script.push_back(chk_row(tess_pkg::OP_PUSH, 0, 32'h1,
                                 mk_res(tess_pkg::ST_FULL, 0, 0, 0, 1, 1, 1)));
        script.push_back(op_row(tess_pkg::OP_SEARCH, 0, 32'h5555_5555));
        script.push_back(cap_row(511));
        script.push_back(chk_row(OP_UNUSED_7, 0, 0,
                                 mk_res(tess_pkg::ST_OK, 0, 0, 0, 0, 0, 0)));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            if (script[i].is_cap)
                write_capacity(script[i].cap);
            else
                send(script[i].op, script[i].which, script[i].val, script[i].typed,
                     script[i].res, (i == script.size() - 1) || script[i + 1].is_cap);
        end

        cap_plan = '{256, 1, 2, 3, 0, 5, 8, 16, 64, 255, 511, 100};
        cap_plan.push_back(CW'($urandom_range(1, 511)));
        for (p = 0; p < cap_plan.size(); p++) begin
            write_capacity(cap_plan[p]);
            eff = (cap_plan[p] == 0) ? 1 :
                  ((int'(cap_plan[p]) > DEPTH) ? DEPTH : int'(cap_plan[p]));
            n = (eff >= 200) ? 250 : 90;
            mode = FILL_RUN;
            left_in_run = eff + 4;
            for (k = 0; k < n; k++) begin
                if (left_in_run == 0) begin
                    mode = t_run_mode'($urandom_range(0, 2));
                    left_in_run = $urandom_range(8, eff + 8);
                end
                if ($urandom_range(0, 39) == 0)
                    calm_tx = ~calm_tx;
                op  = pick_op(mode);
                val = pick_word(op);
                send(op, 1'($urandom_range(0, 1)), val, 1'b0, '0, k == n - 1);
                left_in_run--;
            end
        end

        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Run: %0d operations, %0d results, %0d capacity writes",
                 n_items, n_results, n_cap);
        $display("Run: %0d full pushes, %0d empty pops/peeks, %0d search hits, %0d misses",
                 n_full, n_empty, n_hit, n_miss);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Timeout at %0t", $time);
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
rtl/tess_pkg.sv
rtl/tess_ram.sv
rtl/tess_ctrl.sv
rtl/tess_dp.sv
rtl/two_ended_shared_stack.sv
rtl/tess_chk.sv
tb/tb_two_ended_shared_stack.sv
